// ----- rtl/core/g2l_pkg.sv -----
// shared types, constants and tables for the gregorian to lunar date core
// holds the per-year lunar rom, the days-before-month table and the walk state
// no dependencies
package g2l_pkg;

  localparam int BASE_YEAR   = 1901;
  localparam int ROM_DEPTH   = 199;
  localparam int TABLE_YEARS = 199;
  localparam int LAST_SLOT   = 13;
  localparam int WALK_STAGES = 4;
  localparam int WALK_STEPS  = 3;

  localparam logic [23:0] LUNAR_ROM [ROM_DEPTH] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
    24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
    24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
    24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
    24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
    24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
    24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
    24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
    24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
    24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
    24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
    24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
    24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
    24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
    24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
    24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
    24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
    24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
    24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
    24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
    24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
    24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
    24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic        ok;
    logic        fwd;
    logic [8:0]  rem;
    logic [3:0]  idx;
    logic [3:0]  month;
    logic        leap;
    logic [3:0]  lm;
    logic [12:0] lens;
    logic [11:0] ly;
  } walk_t;

  // month slot 1..13 maps to lens bit 12..0
  function automatic logic [4:0] slot_len(input logic [12:0] lens, input logic [3:0] idx);
    logic [3:0] k;
    k = 4'(LAST_SLOT) - idx;
    return lens[k] ? 5'd30 : 5'd29;
  endfunction

endpackage

// ----- rtl/core/gregorian_to_lunar_date_core.sv -----
// top level of the gregorian to chinese lunar date core
// instantiates g2l_front and a chain of g2l_walk stages; uses g2l_pkg
//
// usage:
//   input channel: date_valid / date_stall with greg_year, greg_month, greg_day.
//   a date is transferred on a rising edge with date_valid high and date_stall low.
//   output channel: lunar_valid / lunar_stall with lunar_year, lunar_month,
//   lunar_day, is_leap_month and valid_res; transferred the same way.
//   pipeline: three front stages, then four walk stages of three month steps each,
//   then one output register; the month walk is spread over the walk stages.
//   throughput: one date per cycle while the output is not stalled.
//   when the receiver stalls a waiting result, the whole pipeline holds and
//   date_stall rises; nothing is lost or repeated.
//   valid_res low means the date is malformed or outside table coverage; the
//   other result fields are then zero.
//   reset clears all valid bits; no clearing pass is needed.
module gregorian_to_lunar_date_core #(
  parameter int TABLE_YEARS = g2l_pkg::TABLE_YEARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        date_valid,
  output logic        date_stall,
  input  logic [11:0] greg_year,
  input  logic [3:0]  greg_month,
  input  logic [4:0]  greg_day,
  output logic        lunar_valid,
  input  logic        lunar_stall,
  output logic [11:0] lunar_year,
  output logic [3:0]  lunar_month,
  output logic [4:0]  lunar_day,
  output logic        is_leap_month,
  output logic        valid_res
);

  logic           adv;
  logic           wk_v [g2l_pkg::WALK_STAGES+1];
  g2l_pkg::walk_t wk   [g2l_pkg::WALK_STAGES+1];
  g2l_pkg::walk_t wf;
  logic [4:0]     len;
  logic [4:0]     day_next;

  assign adv        = !(lunar_valid && lunar_stall);
  assign date_stall = !adv;

  g2l_front #(
    .TABLE_YEARS(TABLE_YEARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_v      (date_valid),
    .greg_year (greg_year),
    .greg_month(greg_month),
    .greg_day  (greg_day),
    .out_v     (wk_v[0]),
    .out_w     (wk[0])
  );

  for (genvar g = 0; g < g2l_pkg::WALK_STAGES; g++) begin : g_walk
    g2l_walk u_walk (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .in_v (wk_v[g]),
      .in_w (wk[g]),
      .out_v(wk_v[g+1]),
      .out_w(wk[g+1])
    );
  end

  always_comb begin
    wf       = wk[g2l_pkg::WALK_STAGES];
    len      = g2l_pkg::slot_len(wf.lens, wf.idx);
    day_next = wf.fwd ? (wf.rem[4:0] + 5'd1) : (len + 5'd1 - wf.rem[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lunar_valid <= 1'b0;
    end else if (adv) begin
      lunar_valid <= wk_v[g2l_pkg::WALK_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      valid_res     <= wf.ok;
      lunar_year    <= wf.ok ? wf.ly : 12'd0;
      lunar_month   <= wf.ok ? wf.month : 4'd0;
      lunar_day     <= wf.ok ? day_next : 5'd0;
      is_leap_month <= wf.ok && wf.leap;
    end
  end

  // invalid results carry zero fields
  assert property (@(posedge clk) disable iff (rst)
    lunar_valid && !valid_res |->
      lunar_year == 12'd0 && lunar_month == 4'd0 && lunar_day == 5'd0 && !is_leap_month)
    else $error("invalid result with nonzero fields");

  // valid results lie in the lunar ranges
  assert property (@(posedge clk) disable iff (rst)
    lunar_valid && valid_res |->
      lunar_day >= 5'd1 && lunar_day <= 5'd30 && lunar_month >= 4'd1 && lunar_month <= 4'd12)
    else $error("lunar month or day out of range");

  // a stalled output freezes the walk pipeline
  assert property (@(posedge clk) disable iff (rst)
    lunar_valid && lunar_stall |=> $stable(wk[0]) && $stable(wk_v[g2l_pkg::WALK_STAGES]))
    else $error("pipeline moved during output stall");

  // an item in the last walk stage reaches the output once the stall clears
  assert property (@(posedge clk) disable iff (rst)
    wk_v[g2l_pkg::WALK_STAGES] && adv |=> lunar_valid)
    else $error("walk result dropped");

endmodule

// ----- rtl/core/g2l_front.sv -----
// front end of the date core: day-of-year, rom lookup and walk setup
// three register stages; uses g2l_pkg tables and walk_t
module g2l_front #(
  parameter int TABLE_YEARS = g2l_pkg::TABLE_YEARS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_v,
  input  logic [11:0]       greg_year,
  input  logic [3:0]        greg_month,
  input  logic [4:0]        greg_day,
  output logic              out_v,
  output g2l_pkg::walk_t    out_w
);

  logic        v1, ok1;
  logic [7:0]  idx1;
  logic [8:0]  doy1;
  logic [11:0] y1;

  logic        v2, ok2;
  logic [7:0]  idx2;
  logic [8:0]  doy2;
  logic [6:0]  sf2;
  logic [11:0] y2;
  logic [23:0] ecur2, eprev2;

  logic [11:0] yoff;
  logic        in_range, leap_yr, ok_next;
  logic [8:0]  doy_next;
  logic [23:0] ecur_next, eprev_next;
  logic [6:0]  sf_next;
  g2l_pkg::walk_t w_next;
  logic [23:0] esel;
  logic [3:0]  lm_raw, lm;

  always_comb begin
    yoff     = greg_year - 12'(g2l_pkg::BASE_YEAR);
    in_range = (greg_year >= 12'(g2l_pkg::BASE_YEAR)) && (yoff < 12'(TABLE_YEARS));
    // within the table every year divisible by 4 is a leap year
    leap_yr  = (greg_year[1:0] == 2'b00);
    ok_next  = (greg_month inside {[4'd1:4'd12]}) && (greg_day != 5'd0) && in_range;
    doy_next = '0;
    if (greg_month inside {[4'd1:4'd12]}) begin
      doy_next = g2l_pkg::DAYS_BEFORE[greg_month - 4'd1];
    end
    doy_next = doy_next + {4'd0, greg_day} - 9'd1
             + {8'd0, leap_yr && (greg_month > 4'd2)};
  end

  always_comb begin
    ecur_next  = '0;
    eprev_next = '0;
    if (idx1 < 8'(g2l_pkg::ROM_DEPTH)) begin
      ecur_next = g2l_pkg::LUNAR_ROM[idx1];
    end
    if (idx1 != 8'd0 && idx1 <= 8'(g2l_pkg::ROM_DEPTH)) begin
      eprev_next = g2l_pkg::LUNAR_ROM[idx1 - 8'd1];
    end
    sf_next = {2'b00, ecur_next[4:0]} - 7'd1
            + ((ecur_next[6:5] != 2'd1) ? 7'd31 : 7'd0);
  end

  always_comb begin
    w_next.fwd = (doy2 >= {2'b00, sf2});
    esel       = w_next.fwd ? ecur2 : eprev2;
    lm_raw     = esel[23:20];
    lm         = (lm_raw inside {[4'd1:4'd12]}) ? lm_raw : 4'd0;
    w_next.ok  = ok2 && (w_next.fwd || idx2 != 8'd0);
    w_next.lm  = lm;
    w_next.lens = esel[19:7];
    if (w_next.fwd) begin
      w_next.rem   = doy2 - {2'b00, sf2};
      w_next.idx   = 4'd1;
      w_next.month = 4'd1;
      w_next.leap  = 1'b0;
      w_next.ly    = y2;
    end else begin
      w_next.rem   = {2'b00, sf2} - doy2;
      w_next.idx   = (lm != 4'd0) ? 4'd13 : 4'd12;
      w_next.month = 4'd12;
      w_next.leap  = (lm == 4'd12);
      w_next.ly    = y2 - 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1    <= ok_next;
      idx1   <= yoff[7:0];
      doy1   <= doy_next;
      y1     <= greg_year;
      ok2    <= ok1;
      idx2   <= idx1;
      doy2   <= doy1;
      sf2    <= sf_next;
      y2     <= y1;
      ecur2  <= ecur_next;
      eprev2 <= eprev_next;
      out_w  <= w_next;
    end
  end

endmodule

// ----- rtl/core/g2l_walk.sv -----
// one stage of the month walk: a few month steps, then a register
// uses g2l_pkg walk_t, slot_len and WALK_STEPS
module g2l_walk (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_v,
  input  g2l_pkg::walk_t in_w,
  output logic           out_v,
  output g2l_pkg::walk_t out_w
);

  function automatic g2l_pkg::walk_t step(input g2l_pkg::walk_t w);
    g2l_pkg::walk_t r;
    logic [4:0] len;
    r   = w;
    len = g2l_pkg::slot_len(w.lens, w.idx);
    if (w.fwd) begin
      if (w.rem >= {4'd0, len} && w.idx < 4'(g2l_pkg::LAST_SLOT)) begin
        r.rem = w.rem - {4'd0, len};
        r.idx = w.idx + 4'd1;
        if (w.month == w.lm && !w.leap) begin
          r.leap = 1'b1;
        end else begin
          r.leap  = 1'b0;
          r.month = w.month + 4'd1;
        end
      end
    end else begin
      if (w.rem > {4'd0, len} && w.idx > 4'd1) begin
        r.rem = w.rem - {4'd0, len};
        r.idx = w.idx - 4'd1;
        if (!w.leap) begin
          r.month = w.month - 4'd1;
        end
        if (r.month == w.lm) begin
          r.leap = !w.leap;
        end
      end
    end
    return r;
  endfunction

  g2l_pkg::walk_t w_next;

  always_comb begin
    w_next = in_w;
    for (int i = 0; i < g2l_pkg::WALK_STEPS; i++) begin
      w_next = step(w_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_w <= w_next;
    end
  end

endmodule

// ----- tb/sv/gregorian_to_lunar_date_core_tb.sv -----
// self-checking testbench for gregorian_to_lunar_date_core: directed and random dates
// against a built-in calendar predictor, with idle, stall, hold-off and drain phases
// depends only on the rtl of the core and its package
module gregorian_to_lunar_date_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIRST_YEAR = 1901;
  localparam int YEAR_COUNT = 199;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 500;
  localparam int RANDOM_DATES = 1400;

  localparam logic [23:0] YEAR_WORD [YEAR_COUNT] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544, 24'h46AAB9, 24'h056A4D,
    24'h09AD42, 24'h24AEB6, 24'h04AE4A, 24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA,
    24'h0B544E, 24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754, 24'h0A4B48,
    24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8, 24'h02B64D, 24'h095742, 24'h2497B7,
    24'h04974A, 24'h664B3E, 24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48, 24'h6DA53B, 24'h0B554F,
    24'h056A45, 24'h4AADB9, 24'h025D4D, 24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD,
    24'h06CA51, 24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8, 24'h052B4C,
    24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C, 24'h0AB54F, 24'h04B645, 24'h4A5739,
    24'h0A574D, 24'h052642, 24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B, 24'h8D52BF, 24'h0B5452,
    24'h0B6A47, 24'h696D3C, 24'h095B50, 24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2,
    24'h06A554, 24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB, 24'h04974F,
    24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF, 24'h05AC53, 24'h0AB647, 24'h5936BC,
    24'h092E50, 24'h0C9645, 24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E, 24'h0B4A43, 24'h4B5537,
    24'h0AD54A, 24'h955ABF, 24'h04BA53, 24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345,
    24'h474AB9, 24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51,
    24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43, 24'h36B537, 24'h096D4B, 24'hB4AEBF,
    24'h04AD53, 24'h0A4D48, 24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51, 24'h0AA546, 24'h5B52BA,
    24'h06D24E, 24'h0ADA42, 24'h355B37, 24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48,
    24'h66A53C, 24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42, 24'h3C9735,
    24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545, 24'h55AABA, 24'h056A4E, 24'h0A6D43,
    24'h452EB7, 24'h052D4B, 24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6, 24'h069349, 24'h7729BD,
    24'h06AA51, 24'h0AD546, 24'h54DABA, 24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A,
    24'h8E933E, 24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45, 24'h4A4EB9,
    24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    bit          drain;
  } greg_date_t;

  typedef struct {
    greg_date_t  src;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic        ok;
  } lunar_date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        date_valid = 1'b0;
  logic        date_stall;
  logic [11:0] greg_year = '0;
  logic [3:0]  greg_month = '0;
  logic [4:0]  greg_day = '0;
  logic        lunar_valid;
  logic        lunar_stall = 1'b0;
  logic [11:0] lunar_year;
  logic [3:0]  lunar_month;
  logic [4:0]  lunar_day;
  logic        is_leap_month;
  logic        valid_res;

  greg_date_t  pending_dates[$];
  lunar_date_t expected_lunar[$];
  int          dates_taken = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  gregorian_to_lunar_date_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .greg_year    (greg_year),
    .greg_month   (greg_month),
    .greg_day     (greg_day),
    .lunar_valid  (lunar_valid),
    .lunar_stall  (lunar_stall),
    .lunar_year   (lunar_year),
    .lunar_month  (lunar_month),
    .lunar_day    (lunar_day),
    .is_leap_month(is_leap_month),
    .valid_res    (valid_res)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit greg_leap(int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic bit year_covered(int y);
    return y >= FIRST_YEAR && y - FIRST_YEAR < YEAR_COUNT;
  endfunction

  function automatic int month_len(logic [23:0] w, int idx);
    return w[20 - idx] ? 30 : 29;
  endfunction

  function automatic lunar_date_t predict_lunar_date(greg_date_t g);
    lunar_date_t r;
    logic [23:0] w;
    int y, m, d, sf, doy, lm, month, idx, len, rem, ly;
    bit leap;
    r = '{src: g, year: '0, month: '0, day: '0, leap: 1'b0, ok: 1'b0};
    y = int'(g.year);
    m = int'(g.month);
    d = int'(g.day);
    if (m < 1 || m > 12 || d < 1 || !year_covered(y)) return r;
    w = YEAR_WORD[y - FIRST_YEAR];
    sf = int'(w[4:0]) - 1;
    if (w[6:5] != 2'd1) sf += 31;
    doy = MONTH_START[m - 1] + d - 1;
    if (greg_leap(y) && m > 2) doy++;
    leap = 1'b0;
    if (doy >= sf) begin
      ly = y;
      lm = (w[23:20] inside {[4'd1:4'd12]}) ? int'(w[23:20]) : 0;
      rem = doy - sf;
      month = 1;
      idx = 1;
      len = month_len(w, idx);
      while (rem >= len && idx < 13) begin
        rem -= len;
        idx++;
        if (month == lm && !leap) begin
          leap = 1'b1;
        end else begin
          leap = 1'b0;
          month++;
        end
        len = month_len(w, idx);
      end
      d = rem + 1;
    end else begin
      ly = y - 1;
      if (!year_covered(ly)) return r;
      w = YEAR_WORD[ly - FIRST_YEAR];
      lm = (w[23:20] inside {[4'd1:4'd12]}) ? int'(w[23:20]) : 0;
      rem = sf - doy;
      month = 12;
      idx = (lm != 0) ? 13 : 12;
      leap = (lm == 12);
      len = month_len(w, idx);
      while (rem > len && idx > 1) begin
        rem -= len;
        idx--;
        if (!leap) month--;
        if (month == lm) leap = !leap;
        len = month_len(w, idx);
      end
      d = len - rem + 1;
    end
    r.year = ly[11:0];
    r.month = month[3:0];
    r.day = d[4:0];
    r.leap = leap;
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic idle_mode_t idle_mode(int n);
    if (n < 40) return IDLE_NONE;
    case (((n - 40) / 200) % 4)
      0: return IDLE_SENDER;
      1: return IDLE_RECEIVER;
      2: return IDLE_BOTH;
      default: return IDLE_NONE;
    endcase
  endfunction

  function automatic bit sender_idles(int n);
    case (idle_mode(n))
      IDLE_SENDER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls(int n);
    case (idle_mode(n))
      IDLE_RECEIVER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_date(int y, int m, int d);
    pending_dates.push_back('{year: y[11:0], month: m[3:0], day: d[4:0], drain: 1'b0});
  endtask

  task automatic add_drain();
    pending_dates.push_back('{year: '0, month: '0, day: '0, drain: 1'b1});
  endtask

  task automatic check_field(string what, lunar_date_t want, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      $display("%0t: %0d-%0d-%0d %s expected %0d actual %0d", $time, want.src.year,
               want.src.month, want.src.day, what, exp_val, act_val);
    end
  endtask

  // random date: mostly in range, biased toward the new year, with some raw noise
  task automatic add_random_date();
    int pick, y, m, dim, d;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      add_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
    end else begin
      if (pick < 13) begin
        case ($urandom_range(0, 3))
          0: y = 1900;
          1: y = 1901;
          2: y = 2099;
          default: y = 2100;
        endcase
      end else begin
        y = $urandom_range(1901, 2099);
      end
      m = (pick < 40) ? $urandom_range(1, 2) : $urandom_range(1, 12);
      dim = MONTH_DAYS[m - 1] + ((m == 2 && greg_leap(y)) ? 1 : 0);
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(dim, 31) : $urandom_range(1, dim);
      add_date(y, m, d);
    end
  endtask

  always @(posedge clk) begin : date_driver
    greg_date_t item;
    if (rst) begin
      date_valid <= 1'b0;
    end else begin
      if (date_valid && !date_stall) begin
        expected_lunar.push_back(predict_lunar_date('{year: greg_year, month: greg_month,
                                                       day: greg_day, drain: 1'b0}));
        dates_taken <= dates_taken + 1;
      end
      if (!(date_valid && date_stall)) begin
        if (pending_dates.size() > 0 && pending_dates[0].drain && expected_lunar.size() == 0)
          void'(pending_dates.pop_front());
        if (pending_dates.size() > 0 && !pending_dates[0].drain && !sender_idles(dates_taken)) begin
          item = pending_dates.pop_front();
          date_valid <= 1'b1;
          greg_year <= item.year;
          greg_month <= item.month;
          greg_day <= item.day;
        end else begin
          date_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : lunar_monitor
    lunar_date_t want;
    int hold_left;
    bit hold_done;
    if (rst) begin
      lunar_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (lunar_valid && !lunar_stall) begin
        if (expected_lunar.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, actual %0d-%0d-%0d leap %0d ok %0d",
                   $time, lunar_year, lunar_month, lunar_day, is_leap_month, valid_res);
        end else begin
          want = expected_lunar.pop_front();
          check_field("lunar_year", want, int'(want.year), int'(lunar_year));
          check_field("lunar_month", want, int'(want.month), int'(lunar_month));
          check_field("lunar_day", want, int'(want.day), int'(lunar_day));
          check_field("is_leap_month", want, int'(want.leap), int'(is_leap_month));
          check_field("valid_res", want, int'(want.ok), int'(valid_res));
        end
      end
      // one long hold-off while the sender keeps offering
      if (!hold_done && dates_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        lunar_stall <= 1'b1;
      end else begin
        lunar_stall <= receiver_stalls(dates_taken);
      end
    end
  end

  always @(posedge clk) begin
    if ((date_valid && !date_stall) || (lunar_valid && !lunar_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // first valid day, the days just before coverage starts, and days of the last table year
    add_date(1901, 1, 1);
    add_date(1901, 2, 18);
    add_date(1901, 2, 19);
    add_date(2099, 12, 31);
    add_date(2099, 1, 1);
    // gregorian leap days
    add_date(2000, 2, 29);
    add_date(2000, 3, 1);
    add_date(1904, 2, 29);
    // regular and inserted second month, inserted eleventh month
    add_date(2023, 2, 25);
    add_date(2023, 3, 25);
    add_date(2024, 1, 15);
    add_date(2033, 12, 25);
    add_date(2034, 1, 10);
    // days past month end
    add_date(2021, 2, 31);
    add_date(2021, 4, 31);
    // malformed fields and years outside the table
    add_date(2021, 0, 10);
    add_date(2021, 13, 1);
    add_date(2021, 15, 31);
    add_date(2021, 5, 0);
    add_date(1900, 6, 1);
    add_date(2100, 1, 1);
    add_date(0, 0, 0);
    add_date(4095, 15, 31);
    add_drain();
    for (int i = 0; i < RANDOM_DATES; i++) begin
      if (i == 700) add_drain();
      add_random_date();
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_dates.size() != 0 || date_valid || expected_lunar.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/g2l_pkg.sv
rtl/core/g2l_front.sv
rtl/core/g2l_walk.sv
rtl/core/gregorian_to_lunar_date_core.sv
tb/sv/gregorian_to_lunar_date_core_tb.sv
